/* hdl/mtss_pkg.sv */
// Shared types and constants for the motor test switch session block.
// No dependencies; every other file in hdl/ imports this package.
package mtss_pkg;

   // operation codes of the input item
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // status codes
   localparam logic [4:0] ST_DISABLED     = 5'd0;
   localparam logic [4:0] ST_STOPPED      = 5'd1;
   localparam logic [4:0] ST_ARMED        = 5'd2;
   localparam logic [4:0] ST_HOST_DOWN    = 5'd3;
   localparam logic [4:0] ST_LINK_BAD     = 5'd4;
   localparam logic [4:0] ST_CALIBRATING  = 5'd5;
   localparam logic [4:0] ST_RX_STALE     = 5'd6;
   localparam logic [4:0] ST_RX_MISSING   = 5'd7;
   localparam logic [4:0] ST_THROTTLE_HI  = 5'd8;
   localparam logic [4:0] ST_AUX_INVALID  = 5'd9;
   localparam logic [4:0] ST_AUX_NOT_LOW  = 5'd10;
   localparam logic [4:0] ST_WAIT_LOW     = 5'd11;
   localparam logic [4:0] ST_WAIT_HIGH    = 5'd12;
   localparam logic [4:0] ST_EXPIRED      = 5'd13;
   localparam logic [4:0] ST_GAP          = 5'd14;
   localparam logic [4:0] ST_RUNNING      = 5'd15;
   localparam logic [4:0] ST_RUN_LIMIT    = 5'd16;
   localparam logic [4:0] ST_CLEAR        = 5'd0;   // no interlock failing

   // register map (word index)
   localparam int          CSR_ADDR_W         = 5;
   localparam int          CSR_DATA_W         = 32;
   localparam logic [2:0]  REG_SESSION_LIMIT  = 3'd0;
   localparam logic [2:0]  REG_TICK_GAP_LIMIT = 3'd1;
   localparam logic [2:0]  REG_RUN_LIMIT      = 3'd2;
   localparam logic [2:0]  REG_THROTTLE_LOW   = 3'd3;
   localparam logic [2:0]  REG_AUX_HIGH       = 3'd4;

   localparam logic signed [15:0] Q_ONE     = 16'sd8192;
   localparam logic signed [15:0] Q_NEG_ONE = -16'sd8192;

   typedef struct packed {
      logic [1:0]         op;
      logic [31:0]        now_ms;
      logic               flight_armed;
      logic               host_link_up;
      logic               motor_link_healthy;
      logic               calibrating;
      logic               receiver_fresh;
      logic               channels_present;
      logic signed [15:0] throttle_level;
      logic signed [15:0] aux_level;
      logic               other_test_active;
   } req_item_type;

   typedef struct packed {
      logic       drive_on;
      logic       session_on;
      logic       start_accepted;
      logic [4:0] status_code;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] session_limit_ms;
      logic [15:0] tick_gap_limit_ms;
      logic [15:0] run_limit_ms;
      logic [14:0] throttle_low_max;
      logic [14:0] aux_high_min;
   } cfg_type;

   typedef struct packed {
      logic        session_enabled;
      logic        low_witnessed;
      logic        drive_running;
      logic [31:0] session_start;
      logic [31:0] last_tick;
      logic [31:0] run_start;
      logic [4:0]  status;
   } sess_state_type;

endpackage

/* hdl/mtss_channels.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on mtss_pkg for the payload types.
interface mtss_req_if;
   import mtss_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface mtss_rsp_if;
   import mtss_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

/* hdl/motor_test_switch_session.sv */
// Top level of the motor test switch session interlock.
// Depends on mtss_pkg, mtss_channels, mtss_csr and mtss_step.
//
// Usage:
//  - req_ch carries start, stop and output-tick items; rsp_ch returns exactly
//    one item (drive_on, session_on, start_accepted, status_code) per request.
//  - csr_* is an APB-style port holding the session, tick-gap and run limits
//    and the throttle-low / aux-high thresholds; write it only while idle.
//  - Throughput: one item per cycle unless rsp_ch stalls. Each item passes
//    an input register, a single pass of interlock checks and three 32-bit
//    elapsed-time compares, and lands in the result register together with
//    the session state.
//  - If rsp_ch stalls, the result register holds and the input register
//    still takes one more item; req_ch.ready falls only when both are full.
//  - Reset (synchronous, active high) empties both registers, closes any
//    session, clears the timers and status, and loads the default limits.
module motor_test_switch_session (
   input  logic                            clock,
   input  logic                            reset,
   mtss_req_if.sink                        req_ch,
   mtss_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mtss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mtss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mtss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import mtss_pkg::*;

   cfg_type        cfg;
   logic           in_valid_ff;
   req_item_type   in_item_ff;
   logic           out_valid_ff;
   rsp_item_type   out_item_ff;
   sess_state_type state_ff;
   sess_state_type state_in;
   rsp_item_type   res_in;
   logic           advance;

   mtss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mtss_step u_step (
      .item (in_item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .res  (res_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff <= req_ch.item;
      end
      if (advance) begin
         out_item_ff <= res_in;
      end
   end

   // motors only driven inside an open session
   a_drive_in_session: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.drive_on |-> out_item_ff.session_on)
      else $error("drive_on without an open session");

   // running status is only ever reported while the session is open
   a_running_in_session: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.status_code == ST_RUNNING |-> out_item_ff.session_on)
      else $error("running status outside a session");

   a_accept_opens: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.start_accepted |->
         out_item_ff.session_on && out_item_ff.status_code == ST_WAIT_LOW)
      else $error("accepted start did not open a session");

   a_drive_state: assert property (@(posedge clock) disable iff (reset)
      state_ff.drive_running |-> state_ff.session_enabled && !state_ff.low_witnessed)
      else $error("drive state outside a session");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");
endmodule

/* hdl/mtss_csr.sv */
// APB-style configuration registers (limits and thresholds).
// Depends on mtss_pkg for the register map and cfg_type.
module mtss_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mtss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mtss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mtss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output mtss_pkg::cfg_type               cfg
);
   import mtss_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.session_limit_ms  <= 32'd60000;
         cfg_ff.tick_gap_limit_ms <= 16'd20;
         cfg_ff.run_limit_ms      <= 16'd3000;
         cfg_ff.throttle_low_max  <= 15'd409;
         cfg_ff.aux_high_min      <= 15'd4096;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SESSION_LIMIT:  cfg_ff.session_limit_ms  <= csr_pwdata;
            REG_TICK_GAP_LIMIT: cfg_ff.tick_gap_limit_ms <= csr_pwdata[15:0];
            REG_RUN_LIMIT:      cfg_ff.run_limit_ms      <= csr_pwdata[15:0];
            REG_THROTTLE_LOW:   cfg_ff.throttle_low_max  <= csr_pwdata[14:0];
            REG_AUX_HIGH:       cfg_ff.aux_high_min      <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SESSION_LIMIT:  csr_prdata = cfg_ff.session_limit_ms;
         REG_TICK_GAP_LIMIT: csr_prdata = {16'd0, cfg_ff.tick_gap_limit_ms};
         REG_RUN_LIMIT:      csr_prdata = {16'd0, cfg_ff.run_limit_ms};
         REG_THROTTLE_LOW:   csr_prdata = {17'd0, cfg_ff.throttle_low_max};
         REG_AUX_HIGH:       csr_prdata = {17'd0, cfg_ff.aux_high_min};
         default:            csr_prdata = '0;
      endcase
   end
endmodule

/* hdl/mtss_step.sv */
// Next-state and result logic for one item: interlocks, timers, switch edge.
// Depends on mtss_pkg for item, state and config types.
module mtss_step (
   input  mtss_pkg::req_item_type   item,
   input  mtss_pkg::sess_state_type cur,
   input  mtss_pkg::cfg_type        cfg,
   output mtss_pkg::sess_state_type nxt,
   output mtss_pkg::rsp_item_type   res
);
   import mtss_pkg::*;

   logic [4:0]  blk;
   logic [31:0] sess_age;
   logic [31:0] tick_gap;
   logic [31:0] run_age;
   logic        thr_bad;
   logic        aux_bad;
   logic        aux_high;
   logic        run_go;
   logic        drive;
   logic        accepted;

   // throttle outside 0..throttle_low_max, aux outside -1.0..1.0
   assign thr_bad  = item.throttle_level[15] ||
                     (item.throttle_level[14:0] > cfg.throttle_low_max);
   assign aux_bad  = (item.aux_level < Q_NEG_ONE) || (item.aux_level > Q_ONE);
   assign aux_high = !item.aux_level[15] && (item.aux_level[14:0] > cfg.aux_high_min);

   always_comb begin
      priority if (item.flight_armed)        blk = ST_ARMED;
      else if (!item.host_link_up)           blk = ST_HOST_DOWN;
      else if (!item.motor_link_healthy)     blk = ST_LINK_BAD;
      else if (item.calibrating)             blk = ST_CALIBRATING;
      else if (!item.receiver_fresh)         blk = ST_RX_STALE;
      else if (!item.channels_present)       blk = ST_RX_MISSING;
      else if (thr_bad)                      blk = ST_THROTTLE_HI;
      else if (aux_bad)                      blk = ST_AUX_INVALID;
      else                                   blk = ST_CLEAR;
   end

   assign sess_age = item.now_ms - cur.session_start;
   assign tick_gap = item.now_ms - cur.last_tick;
   // a fresh high edge restarts the burst at this tick's time
   assign run_go   = cur.low_witnessed || cur.drive_running;
   assign run_age  = item.now_ms - (cur.low_witnessed ? item.now_ms : cur.run_start);

   always_comb begin
      nxt      = cur;
      drive    = 1'b0;
      accepted = 1'b0;
      unique case (item.op)
         OP_START: begin
            if (!cur.session_enabled && !item.other_test_active) begin
               if (blk != ST_CLEAR) begin
                  nxt.status = blk;
               end else if (!item.aux_level[15]) begin
                  nxt.status = ST_AUX_NOT_LOW;
               end else begin
                  nxt.session_enabled = 1'b1;
                  nxt.low_witnessed   = 1'b0;
                  nxt.drive_running   = 1'b0;
                  nxt.status          = ST_WAIT_LOW;
                  nxt.session_start   = item.now_ms;
                  nxt.last_tick       = item.now_ms;
                  accepted            = 1'b1;
               end
            end
         end
         OP_STOP: begin
            nxt.session_enabled = 1'b0;
            nxt.low_witnessed   = 1'b0;
            nxt.drive_running   = 1'b0;
            nxt.status          = ST_STOPPED;
         end
         OP_TICK: begin
            if (cur.session_enabled) begin
               nxt.last_tick = item.now_ms;
               if (blk != ST_CLEAR || sess_age >= cfg.session_limit_ms ||
                   tick_gap > {16'd0, cfg.tick_gap_limit_ms}) begin
                  nxt.session_enabled = 1'b0;
                  nxt.low_witnessed   = 1'b0;
                  nxt.drive_running   = 1'b0;
                  priority if (blk != ST_CLEAR)                   nxt.status = blk;
                  else if (sess_age >= cfg.session_limit_ms)      nxt.status = ST_EXPIRED;
                  else                                            nxt.status = ST_GAP;
               end else if (item.aux_level[15]) begin
                  nxt.low_witnessed = 1'b1;
                  nxt.drive_running = 1'b0;
                  nxt.status        = ST_WAIT_HIGH;
               end else if (!aux_high) begin
                  nxt.drive_running = 1'b0;
                  nxt.status        = cur.low_witnessed ? ST_WAIT_HIGH : ST_WAIT_LOW;
               end else begin
                  if (cur.low_witnessed) begin
                     nxt.low_witnessed = 1'b0;
                     nxt.run_start     = item.now_ms;
                     nxt.status        = ST_RUNNING;
                  end
                  if (run_go && run_age >= {16'd0, cfg.run_limit_ms}) begin
                     nxt.drive_running = 1'b0;
                     nxt.status        = ST_RUN_LIMIT;
                  end else begin
                     nxt.drive_running = run_go;
                  end
                  drive = nxt.drive_running;
               end
            end
         end
         default: ;  // unused op: no change
      endcase
   end

   assign res.drive_on       = drive;
   assign res.session_on     = nxt.session_enabled;
   assign res.start_accepted = accepted;
   assign res.status_code    = nxt.status;
endmodule
